// ===== rtl/gibs_pkg.sv =====
// Shared types, constants and bit functions for the genotype IBS counter.
`default_nettype none

package gibs_pkg;

	localparam int WORD_W = 64;
	localparam int SLOTS = WORD_W / 2;
	localparam int POP_W = $clog2(SLOTS + 1);
	localparam int CNT_W = 22;

	localparam logic [WORD_W-1:0] LOW_BITS = 64'h5555_5555_5555_5555;
	localparam logic [WORD_W-1:0] MISSING_CODE = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Per-word slot counts handed from the classify stage to the accumulator.
	typedef struct packed {
		logic last;
		logic [POP_W-1:0] ibs0_n;
		logic [POP_W-1:0] ibs1_n;
		logic [POP_W-1:0] ibs2_n;
	} slot_counts_t;

	// One bit per slot at its low bit position, set where the slot is missing.
	function automatic logic [WORD_W-1:0] missing_mask(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] eq;
		eq = ~(w ^ MISSING_CODE);
		return (eq >> 1) & eq & LOW_BITS;
	endfunction

	// Gather the low bit of every slot into a dense vector.
	function automatic logic [SLOTS-1:0] slot_bits(input logic [WORD_W-1:0] w);
		logic [SLOTS-1:0] r;
		for (int k = 0; k < SLOTS; k++) begin
			r[k] = w[2*k];
		end
		return r;
	endfunction

	// Adder tree over 32 bits: five levels of independent narrow adds.
	function automatic logic [POP_W-1:0] popcount32(input logic [SLOTS-1:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

	// Add a word's count to a running total, pinned at the counter maximum.
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
			input logic [POP_W-1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, acc} + {{(CNT_W + 1 - POP_W){1'b0}}, inc};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gibs_classify.sv =====
// Classify stage: sort the slots of a word pair into IBS classes and count them.
`default_nettype none

module gibs_classify
	import gibs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [WORD_W-1:0] x_word,
	input  wire logic [WORD_W-1:0] y_word,
	input  wire logic              last_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output slot_counts_t           out_item
);

	logic [WORD_W-1:0] same;
	logic [WORD_W-1:0] hi;
	logic [WORD_W-1:0] valid_slots;
	logic [WORD_W-1:0] m0;
	logic [WORD_W-1:0] m1;
	logic [WORD_W-1:0] m2;
	slot_counts_t      item_d;
	logic              valid_s2;
	slot_counts_t      item_s2;

	always_comb begin
		same = ~(x_word ^ y_word);
		hi = same >> 1;
		valid_slots = LOW_BITS & ~(missing_mask(x_word) | missing_mask(y_word));
		// both bits equal, one bit equal, no bit equal
		m2 = hi & same & valid_slots;
		m1 = (hi ^ same) & valid_slots;
		m0 = ~(hi | same) & valid_slots;
		item_d.last = last_word;
		item_d.ibs0_n = popcount32(slot_bits(m0));
		item_d.ibs1_n = popcount32(slot_bits(m1));
		item_d.ibs2_n = popcount32(slot_bits(m2));
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s2 <= item_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item = item_s2;

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ({1'b0, item_s2.ibs0_n} + {1'b0, item_s2.ibs1_n}
			+ {1'b0, item_s2.ibs2_n}) <= (POP_W + 1)'(SLOTS))
		else $error("slot counts of one word exceed the slot count");

endmodule

`default_nettype wire

// ===== rtl/gibs_accum.sv =====
// Accumulator stage: saturating IBS totals and the result register.
`default_nettype none

module gibs_accum
	import gibs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire slot_counts_t     in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [CNT_W-1:0]      ibs0_count,
	output logic [CNT_W-1:0]      ibs1_count,
	output logic [CNT_W-1:0]      ibs2_count
);

	logic [CNT_W-1:0] acc0_q;
	logic [CNT_W-1:0] acc1_q;
	logic [CNT_W-1:0] acc2_q;
	logic [CNT_W-1:0] sum0;
	logic [CNT_W-1:0] sum1;
	logic [CNT_W-1:0] sum2;
	logic             out_valid_q;
	logic [CNT_W-1:0] res0_q;
	logic [CNT_W-1:0] res1_q;
	logic [CNT_W-1:0] res2_q;
	logic             out_free;
	logic             consume;
	logic             consume_last;

	assign sum0 = sat_add(acc0_q, in_item.ibs0_n);
	assign sum1 = sat_add(acc1_q, in_item.ibs1_n);
	assign sum2 = sat_add(acc2_q, in_item.ibs2_n);

	// A last item needs room in the result register; others always pass.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !in_item.last || out_free;
	assign consume = in_valid && in_ready;
	assign consume_last = consume && in_item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc0_q <= '0;
			acc1_q <= '0;
			acc2_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (consume) begin
				if (in_item.last) begin
					acc0_q <= '0;
					acc1_q <= '0;
					acc2_q <= '0;
				end else begin
					acc0_q <= sum0;
					acc1_q <= sum1;
					acc2_q <= sum2;
				end
			end
			if (consume_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume_last) begin
			res0_q <= sum0;
			res1_q <= sum1;
			res2_q <= sum2;
		end
	end

	assign out_valid = out_valid_q;
	assign ibs0_count = res0_q;
	assign ibs1_count = res1_q;
	assign ibs2_count = res2_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		consume_last |=> (acc0_q == '0) && (acc1_q == '0) && (acc2_q == '0))
		else $error("totals not cleared after a last item");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		consume_last |-> out_free)
		else $error("result register overwritten before it was taken");

	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && !in_item.last) |=> (acc0_q >= $past(acc0_q))
			&& (acc1_q >= $past(acc1_q)) && (acc2_q >= $past(acc2_q)))
		else $error("running total decreased within a pair");

endmodule

`default_nettype wire

// ===== rtl/genotype_ibs_counter.sv =====
// Top level of the genotype IBS counter: input register and stage wiring.
`default_nettype none

// Streams pairs of 64-bit genotype words (32 two-bit slots each: 00 hom-ref,
// 01 het, 11 hom-alt, 10 missing) and counts, per sample pair, the slots with
// two, one or no shared alleles, skipping slots missing in either sample.
// Totals saturate at 2^22-1. The word flagged by s_axis_tlast also counts; it
// produces one result on m_axis and clears the totals for the next pair.
// One item is accepted every cycle while the stream does not stall. A last
// item, once accepted, passes the input register and the classify and
// popcount register, and its sums then load the result register. Only a
// result waiting in the result register while a further last item arrives
// stalls the stream; other items keep flowing.
module genotype_ibs_counter
	import gibs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,  // x_word[63:0], y_word[127:64]
	input  wire logic         s_axis_tlast,  // last_word
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata   // ibs0_count[21:0], ibs1_count[43:22],
	                                         // ibs2_count[65:44], zero [71:66]
);

	logic              valid_s1;
	logic [WORD_W-1:0] x_s1;
	logic [WORD_W-1:0] y_s1;
	logic              last_s1;
	logic              cls_ready;
	logic              cls_valid;
	slot_counts_t      cls_item;
	logic              acc_ready;
	logic [CNT_W-1:0]  ibs0_count;
	logic [CNT_W-1:0]  ibs1_count;
	logic [CNT_W-1:0]  ibs2_count;

	assign s_axis_tready = !valid_s1 || cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			x_s1 <= s_axis_tdata[WORD_W-1:0];
			y_s1 <= s_axis_tdata[2*WORD_W-1:WORD_W];
			last_s1 <= s_axis_tlast;
		end
	end

	gibs_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (cls_ready),
		.x_word    (x_s1),
		.y_word    (y_s1),
		.last_word (last_s1),
		.out_valid (cls_valid),
		.out_ready (acc_ready),
		.out_item  (cls_item)
	);

	gibs_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cls_valid),
		.in_ready   (acc_ready),
		.in_item    (cls_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.ibs0_count (ibs0_count),
		.ibs1_count (ibs1_count),
		.ibs2_count (ibs2_count)
	);

	assign m_axis_tdata = {6'b0, ibs2_count, ibs1_count, ibs0_count};

	a_ready_only_blocked_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && !cls_ready)
		else $error("input stalled with a free input register");

endmodule

`default_nettype wire

// ===== test/tb_genotype_ibs_counter.sv =====
// Self-checking stream testbench for the genotype IBS counter.
`default_nettype none

module tb_genotype_ibs_counter
	import gibs_pkg::*;
();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_STALL = 400;

	typedef enum logic [1:0] {
		GT_HOM_REF = 2'b00,
		GT_HET     = 2'b01,
		GT_MISSING = 2'b10,
		GT_HOM_ALT = 2'b11
	} genotype_e;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic last;
	} word_pair_t;

	typedef struct packed {
		logic [CNT_W-1:0] ibs2;
		logic [CNT_W-1:0] ibs1;
		logic [CNT_W-1:0] ibs0;
	} ibs_totals_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;

	word_pair_t feed_q[$];
	ibs_totals_t pair_results[$];
	ibs_totals_t pair_totals = '0;
	logic in_done = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_req = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int err_count = 0;

	genotype_ibs_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("ERROR @%0d: %s", cycle_count, msg);
		err_count++;
	endtask

	function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] acc, input int n);
		int s;
		s = int'(acc) + n;
		if (s > int'(CNT_MAX))
			return CNT_MAX;
		return s[CNT_W-1:0];
	endfunction

	// Classify every slot pair and fold the counts into the running totals.
	function automatic ibs_totals_t count_word(input ibs_totals_t acc,
			input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y);
		logic [1:0] gx;
		logic [1:0] gy;
		int diff;
		int n0;
		int n1;
		int n2;
		n0 = 0;
		n1 = 0;
		n2 = 0;
		for (int k = 0; k < SLOTS; k++) begin
			gx = x[2*k +: 2];
			gy = y[2*k +: 2];
			if (gx != GT_MISSING && gy != GT_MISSING) begin
				diff = int'(gx[0] ^ gy[0]) + int'(gx[1] ^ gy[1]);
				if (diff == 0)
					n2++;
				else if (diff == 1)
					n1++;
				else
					n0++;
			end
		end
		acc.ibs0 = sat_sum(acc.ibs0, n0);
		acc.ibs1 = sat_sum(acc.ibs1, n1);
		acc.ibs2 = sat_sum(acc.ibs2, n2);
		return acc;
	endfunction

	function automatic logic [1:0] called_genotype();
		case ($urandom_range(2))
			0: return GT_HOM_REF;
			1: return GT_HET;
			default: return GT_HOM_ALT;
		endcase
	endfunction

	// Raw bits half the time, otherwise mostly called genotypes.
	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] w;
		w = {$urandom, $urandom};
		if ($urandom_range(1) == 1) begin
			for (int k = 0; k < SLOTS; k++) begin
				if (w[2*k +: 2] == GT_MISSING && $urandom_range(7) != 0)
					w[2*k +: 2] = called_genotype();
			end
		end
		return w;
	endfunction

	task automatic add_item(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
			input logic last);
		word_pair_t p;
		p.x = x;
		p.y = y;
		p.last = last;
		feed_q.push_back(p);
	endtask

	// Queue whole sample pairs of random length, each closed by a last word.
	task automatic queue_pairs(input int n_items);
		int left;
		int len;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++) begin
				x = random_word();
				if ($urandom_range(1) == 0) begin
					y = random_word();
				end else begin
					// related samples: copy and disturb a few slots
					y = x;
					for (int j = $urandom_range(4); j > 0; j--)
						y[2*$urandom_range(SLOTS - 1) +: 2] = 2'($urandom_range(3));
				end
				add_item(x, y, i == len - 1);
			end
			left -= len;
		end
	endtask

	task automatic drain();
		while (feed_q.size() != 0 || s_axis_tvalid || pair_results.size() != 0)
			@(posedge clk);
	endtask

	// Sender: offer the next item once the current one is taken.
	always @(negedge clk) begin
		word_pair_t p;
		if (arst_n && (!s_axis_tvalid || in_done)) begin
			in_done = 1'b0;
			if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				p = feed_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {p.y, p.x};
				s_axis_tlast <= p.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, started on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
			end else if (stall_seen != stall_req) begin
				stall_seen <= stall_req;
				stall_left <= LONG_STALL;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// Predict on every accepted item, check every accepted result.
	always @(posedge clk) begin
		ibs_totals_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				if (s_axis_tvalid && s_axis_tready) begin
					in_done = 1'b1;
					pair_totals = count_word(pair_totals, s_axis_tdata[63:0],
						s_axis_tdata[127:64]);
					if (s_axis_tlast) begin
						pair_results.push_back(pair_totals);
						pair_totals = '0;
					end
				end
				if (m_axis_tvalid && m_axis_tready) begin
					if (pair_results.size() == 0) begin
						report($sformatf("unexpected result %h", m_axis_tdata));
					end else begin
						want = pair_results.pop_front();
						if (m_axis_tdata[21:0] != want.ibs0)
							report($sformatf("ibs0_count %0d, want %0d",
								m_axis_tdata[21:0], want.ibs0));
						if (m_axis_tdata[43:22] != want.ibs1)
							report($sformatf("ibs1_count %0d, want %0d",
								m_axis_tdata[43:22], want.ibs1));
						if (m_axis_tdata[65:44] != want.ibs2)
							report($sformatf("ibs2_count %0d, want %0d",
								m_axis_tdata[65:44], want.ibs2));
					end
				end
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: uniform words, missing slots, every code pairing.
		send_idle_pct = 31;
		recv_idle_pct = 70;
		add_item('0, '0, 1'b1);
		add_item('1, '0, 1'b1);
		add_item(LOW_BITS, '0, 1'b1);
		add_item(MISSING_CODE, '0, 1'b1);
		add_item('0, MISSING_CODE, 1'b1);
		add_item(MISSING_CODE, MISSING_CODE, 1'b1);
		add_item('1, '1, 1'b0);
		add_item(LOW_BITS, '1, 1'b0);
		add_item('0, '1, 1'b0);
		add_item(LOW_BITS, LOW_BITS, 1'b1);
		for (int k = 0; k < SLOTS; k++) begin
			x[2*k +: 2] = k[1:0];
			y[2*k +: 2] = k[3:2];
		end
		add_item(x, y, 1'b1);
		add_item(y, x, 1'b0);
		add_item(x, x, 1'b1);
		add_item(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1);
		for (int i = 0; i < 6; i++)
			add_item(random_word(), random_word(), 1'b1);
		queue_pairs(320);
		drain();

		send_idle_pct = 70;
		recv_idle_pct = 31;
		queue_pairs(320);
		drain();

		// Hold the receiver while the sender streams short pairs.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_pairs(310);
		stall_req++;
		drain();

		repeat (10) @(posedge clk);
		if (pair_results.size() != 0)
			report($sformatf("%0d results never arrived", pair_results.size()));
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
